// File: design/pgiw_pkg.sv
// Shared types, constants and helpers for the periodic grid interpolation weight block.
// Used by every module under design/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pgiw_pkg;

    // Grid size limits
    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;

    // Item queue between the front and back parts
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);

    // Configuration register indexes
    localparam logic [2:0] CFG_INV_M00   = 3'd0;
    localparam logic [2:0] CFG_INV_M01   = 3'd1;
    localparam logic [2:0] CFG_INV_M10   = 3'd2;
    localparam logic [2:0] CFG_INV_M11   = 3'd3;
    localparam logic [2:0] CFG_GRID_COLS = 3'd4;
    localparam logic [2:0] CFG_GRID_ROWS = 3'd5;

    localparam logic [16:0] WEIGHT_ONE = 17'd65536;

    typedef enum logic [1:0] {
        MODE_VERTEX = 2'd0,
        MODE_EDGE   = 2'd1,
        MODE_FACE   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // One result item
    typedef struct packed {
        logic [16:0]        elem_index;
        logic signed [15:0] cell_off_x;
        logic signed [15:0] cell_off_y;
        logic [16:0]        weight;
        logic               component;
    } t_res;

    // All results of one input item; last_k is the slot of the final one
    typedef struct packed {
        t_res [3:0] res;
        logic [1:0] last_k;
    } t_item;

    // Effective configuration seen by the datapath
    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic [8:0]         nx;
        logic [8:0]         ny;
    } t_cfg;

    // Saturate to a signed 16-bit offset
    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -34'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // A count of zero acts as one; a count above the limit clamps to it
    function automatic logic [8:0] eff_count(input logic [8:0] v, input logic [8:0] maxv);
        logic [8:0] r;
        if (v == 9'd0) begin
            r = 9'd1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/pgiw_front.sv
// Front part: accepts points, maps them to lattice cells and builds the result set.
// Depends on pgiw_pkg. Six-stage free-running pipeline with credit-based admission.
`timescale 1ns / 1ps
`default_nettype none

module pgiw_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pgiw_pkg::t_cfg i_cfg,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [31:0]    i_pos_x,
    input  wire logic [31:0]    i_pos_y,
    input  wire logic [1:0]     i_mode,
    input  wire logic           i_pop,
    output logic                o_push,
    output pgiw_pkg::t_item     o_item
);
    import pgiw_pkg::*;

    // Credit: items inside the pipeline plus items held in the queue
    logic [QAW:0] r_inflight, n_inflight;
    logic         acc;

    assign o_ready = (r_inflight < (QAW+1)'(QDEPTH));
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_inflight = r_inflight;
        if (acc && (t_mode'(i_mode) != MODE_NONE)) begin
            n_inflight = n_inflight + (QAW+1)'(1);
        end
        if (i_pop) begin
            n_inflight = n_inflight - (QAW+1)'(1);
        end
    end

    // Stage valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_inflight <= n_inflight;
            r_v1 <= acc && (t_mode'(i_mode) != MODE_NONE);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // Stage 1: input register
    logic signed [31:0] r_x1, r_y1;
    t_mode r_m1, r_m2, r_m3, r_m4, r_m5;

    always_ff @(posedge i_clk) begin
        r_x1 <= i_pos_x;
        r_y1 <= i_pos_y;
        r_m1 <= t_mode'(i_mode);
    end

    // Stage 2: four matrix products, exact Q32.32
    logic signed [63:0] r_p00, r_p01, r_p10, r_p11;

    always_ff @(posedge i_clk) begin
        r_p00 <= 64'($signed(i_cfg.m00)) * 64'(r_x1);
        r_p01 <= 64'($signed(i_cfg.m01)) * 64'(r_y1);
        r_p10 <= 64'($signed(i_cfg.m10)) * 64'(r_x1);
        r_p11 <= 64'($signed(i_cfg.m11)) * 64'(r_y1);
        r_m2  <= r_m1;
    end

    // Stage 3: split into floored period offset and Q0.32 fraction
    logic [32:0]        lo_x, lo_y;
    logic [33:0]        ip_x, ip_y;
    logic signed [15:0] r_offx3, r_offy3;
    logic [31:0]        r_fgx, r_fgy;

    always_comb begin
        lo_x = {1'b0, r_p00[31:0]} + {1'b0, r_p01[31:0]};
        lo_y = {1'b0, r_p10[31:0]} + {1'b0, r_p11[31:0]};
        ip_x = {{2{r_p00[63]}}, r_p00[63:32]} + {{2{r_p01[63]}}, r_p01[63:32]}
             + {33'd0, lo_x[32]};
        ip_y = {{2{r_p10[63]}}, r_p10[63:32]} + {{2{r_p11[63]}}, r_p11[63:32]}
             + {33'd0, lo_y[32]};
    end

    always_ff @(posedge i_clk) begin
        r_offx3 <= sat16($signed(ip_x));
        r_offy3 <= sat16($signed(ip_y));
        r_fgx   <= lo_x[31:0];
        r_fgy   <= lo_y[31:0];
        r_m3    <= r_m2;
    end

    // Stage 4: scale fraction by cell count -> cell index and local fraction
    logic [40:0]        tx, ty;
    logic [8:0]         r_ix, r_iy;
    logic [15:0]        r_fx4, r_fy4;
    logic signed [15:0] r_offx4, r_offy4;

    assign tx = 41'(r_fgx) * 41'(i_cfg.nx);
    assign ty = 41'(r_fgy) * 41'(i_cfg.ny);

    always_ff @(posedge i_clk) begin
        r_ix    <= tx[40:32];
        r_iy    <= ty[40:32];
        r_fx4   <= tx[31:16];
        r_fy4   <= ty[31:16];
        r_offx4 <= r_offx3;
        r_offy4 <= r_offy3;
        r_m4    <= r_m3;
    end

    // Stage 5: neighbour cells with wrap, row bases, complementary fractions
    logic [9:0]         cx_w, cy_w;
    logic               wrap_x, wrap_y;
    logic [8:0]         cx, cy;
    logic [8:0]         r_ix5, r_iy5, r_cx5, r_cy5;
    logic [17:0]        r_rowi, r_rowc;
    logic [16:0]        r_fx5, r_fy5, r_gx5, r_gy5;
    logic signed [15:0] r_offx5, r_offy5, r_offxc5, r_offyc5;

    always_comb begin
        cx_w   = {1'b0, r_ix} + 10'd1;
        cy_w   = {1'b0, r_iy} + 10'd1;
        wrap_x = (cx_w >= {1'b0, i_cfg.nx});
        wrap_y = (cy_w >= {1'b0, i_cfg.ny});
        cx     = wrap_x ? 9'd0 : cx_w[8:0];
        cy     = wrap_y ? 9'd0 : cy_w[8:0];
    end

    always_ff @(posedge i_clk) begin
        r_ix5    <= r_ix;
        r_iy5    <= r_iy;
        r_cx5    <= cx;
        r_cy5    <= cy;
        r_rowi   <= 18'(r_iy) * 18'(i_cfg.nx);
        r_rowc   <= 18'(cy) * 18'(i_cfg.nx);
        r_fx5    <= {1'b0, r_fx4};
        r_fy5    <= {1'b0, r_fy4};
        r_gx5    <= WEIGHT_ONE - {1'b0, r_fx4};
        r_gy5    <= WEIGHT_ONE - {1'b0, r_fy4};
        r_offx5  <= r_offx4;
        r_offy5  <= r_offy4;
        r_offxc5 <= sat16(34'(r_offx4) + {33'd0, wrap_x});
        r_offyc5 <= sat16(34'(r_offy4) + {33'd0, wrap_y});
        r_m5     <= r_m4;
    end

    // Stage 6: element indexes, corner weights, result set by mode
    logic [17:0] ii, ci, ic, cc;
    logic [33:0] w0, w1, w2, w3;
    t_item       item;

    always_comb begin
        ii = r_rowi + 18'(r_ix5);
        ci = r_rowi + 18'(r_cx5);
        ic = r_rowc + 18'(r_ix5);
        cc = r_rowc + 18'(r_cx5);
        w0 = 34'(r_gx5) * 34'(r_gy5);
        w1 = 34'(r_fx5) * 34'(r_gy5);
        w2 = 34'(r_gx5) * 34'(r_fy5);
        w3 = 34'(r_fx5) * 34'(r_fy5);

        item = '0;
        unique case (r_m5)
            MODE_VERTEX: begin
                item.res[0] = '{ii[16:0], r_offx5,  r_offy5,  w0[32:16], 1'b0};
                item.res[1] = '{ci[16:0], r_offxc5, r_offy5,  w1[32:16], 1'b0};
                item.res[2] = '{ic[16:0], r_offx5,  r_offyc5, w2[32:16], 1'b0};
                item.res[3] = '{cc[16:0], r_offxc5, r_offyc5, w3[32:16], 1'b0};
                item.last_k = 2'd3;
            end
            MODE_EDGE: begin
                item.res[0] = '{{ii[15:0], 1'b0}, r_offx5,  r_offy5,  r_gy5, 1'b0};
                item.res[1] = '{{ii[15:0], 1'b1}, r_offx5,  r_offy5,  r_gx5, 1'b1};
                item.res[2] = '{{ic[15:0], 1'b0}, r_offx5,  r_offyc5, r_fy5, 1'b0};
                item.res[3] = '{{ci[15:0], 1'b1}, r_offxc5, r_offy5,  r_fx5, 1'b1};
                item.last_k = 2'd3;
            end
            MODE_FACE: begin
                item.res[0] = '{ii[16:0], r_offx5, r_offy5, WEIGHT_ONE, 1'b0};
                item.last_k = 2'd0;
            end
            default: begin
                item = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_item <= item;
    end

    assign o_push = r_v6;

endmodule

`default_nettype wire

// File: design/pgiw_queue.sv
// Short item queue between the front and back parts.
// Depends on pgiw_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module pgiw_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire pgiw_pkg::t_item i_item,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output pgiw_pkg::t_item      o_item
);
    import pgiw_pkg::*;

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_count;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Pointers and fill count; admission upstream keeps it from overflowing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QAW+1)'(1);
                2'b01:   r_count <= r_count - (QAW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

endmodule

`default_nettype wire

// File: design/pgiw_back.sv
// Back part: walks the results of the head item out one per cycle while the receiver is ready.
// Depends on pgiw_pkg. Output register decouples the result channel.
`timescale 1ns / 1ps
`default_nettype none

module pgiw_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire pgiw_pkg::t_item i_q_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output pgiw_pkg::t_res       o_res,
    output logic                 o_last
);
    import pgiw_pkg::*;

    logic [1:0] r_k;
    logic       r_valid;
    logic       load, at_last;

    // Load a new result whenever the queue holds an item and the output register is free or draining
    assign load    = i_q_valid && (!r_valid || i_ready);
    assign at_last = (r_k == i_q_item.last_k);
    assign o_pop   = load && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= at_last ? 2'd0 : r_k + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            o_res  <= i_q_item.res[r_k];
            o_last <= at_last;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

// File: design/periodic_grid_interp_weights.sv
// Top level of the periodic grid interpolation weight block: config registers and wiring.
// Depends on pgiw_pkg, pgiw_front, pgiw_queue and pgiw_back.
//
// Usage:
//   Input stream (s_axis_*): tdata carries pos_x then pos_y (Q16.16), tuser the mode.
//   Output stream (m_axis_*): one item per result; tlast marks the final result of a point.
//   Vertex and edge modes give four results per point, face mode one, mode 3 none.
//   Config channel (i_cfg_*): write register index and data; always ready. Write only
//   while the block is idle.
// Throughput: one result per cycle while the receiver is ready, set by the single output
//   register, so a vertex or edge point takes four result slots and a face point one. Points
//   enter back to back while the eight-entry item queue and the pipeline have room.
// Reset: synchronous, active low; registers return to the identity matrix and a 1x1
//   grid, all in-flight items are discarded.
// Stall: when the receiver holds tready low the output holds, the queue fills and then
//   s_axis_tready drops; no item is lost.
`timescale 1ns / 1ps
`default_nettype none

module periodic_grid_interp_weights (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // [31:0] pos_x, [63:32] pos_y
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] mode
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // [16:0] elem_index, [32:17] cell_off_x,
                                            // [48:33] cell_off_y, [65:49] weight, zero fill
    output logic [0:0]       m_axis_tuser,  // [0] component
    output logic             m_axis_tlast,
    // Configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import pgiw_pkg::*;

    logic [31:0] r_m00, r_m01, r_m10, r_m11;
    logic [8:0]  r_cols, r_rows;
    t_cfg        cfg;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m00  <= 32'd65536;
            r_m01  <= 32'd0;
            r_m10  <= 32'd0;
            r_m11  <= 32'd65536;
            r_cols <= 9'd1;
            r_rows <= 9'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INV_M00:   r_m00  <= i_cfg_data;
                CFG_INV_M01:   r_m01  <= i_cfg_data;
                CFG_INV_M10:   r_m10  <= i_cfg_data;
                CFG_INV_M11:   r_m11  <= i_cfg_data;
                CFG_GRID_COLS: r_cols <= i_cfg_data[8:0];
                CFG_GRID_ROWS: r_rows <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Effective configuration
    always_comb begin
        cfg.m00 = r_m00;
        cfg.m01 = r_m01;
        cfg.m10 = r_m10;
        cfg.m11 = r_m11;
        cfg.nx  = eff_count(r_cols, 9'(MAX_COLS));
        cfg.ny  = eff_count(r_rows, 9'(MAX_ROWS));
    end

    logic  push, pop, q_valid;
    t_item push_item, q_item;
    t_res  res;

    // Front: lattice mapping and classification
    pgiw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pos_x (s_axis_tdata[31:0]),
        .i_pos_y (s_axis_tdata[63:32]),
        .i_mode  (s_axis_tuser),
        .i_pop   (pop),
        .o_push  (push),
        .o_item  (push_item)
    );

    // Item queue
    pgiw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back: result sequencing
    pgiw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, res.weight, res.cell_off_y, res.cell_off_x, res.elem_index};
    assign m_axis_tuser = res.component;

endmodule

`default_nettype wire
